FILE: hdl/ccc_pkg.sv
package ccc_pkg;

	// Control bits that walk down the pipeline beside the payload.
	typedef struct packed {
		logic valid;
		logic hit;
		logic zero;
	} ctl_t;

	// Left shift applied to the centre difference before rotation.
	localparam int DIR_EXT = 24;
	// Left shift applied to the radius before rotation.
	localparam int RAD_EXT = 8;
	// Inverse rotation gain 0.607252935 in Q24.
	localparam int GAIN_BITS = 25;
	localparam logic [GAIN_BITS-1:0] GAIN_INV = 25'd10188014;
	// Product scale removed after the gain multiply.
	localparam int ROUND_SHIFT = 32;

endpackage

FILE: hdl/ccc_front.sv
module ccc_front #(
	parameter int COORD_BITS = 24,
	parameter int RADIUS_BITS = 16,
	parameter int MASK_BITS = 16,
	parameter int DW = 44,
	parameter int UW = 26
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid,
	input  logic                          func,
	input  logic signed [COORD_BITS-1:0]  a_x,
	input  logic signed [COORD_BITS-1:0]  a_y,
	input  logic        [RADIUS_BITS-1:0] a_radius,
	input  logic        [MASK_BITS-1:0]   a_mask,
	input  logic                          a_doomed,
	input  logic signed [COORD_BITS-1:0]  b_x,
	input  logic signed [COORD_BITS-1:0]  b_y,
	input  logic        [RADIUS_BITS-1:0] b_radius,
	input  logic        [MASK_BITS-1:0]   b_category,
	input  logic                          b_doomed,
	output ccc_pkg::ctl_t                 ctl_out,
	output logic signed [DW-1:0]          x_out,
	output logic signed [DW-1:0]          y_out,
	output logic signed [UW-1:0]          u_out,
	output logic signed [COORD_BITS-1:0]  ax_out,
	output logic signed [COORD_BITS-1:0]  ay_out,
	output logic        [RADIUS_BITS-1:0] ar_out
);

	localparam int CW = COORD_BITS + 1;
	localparam int RW = RADIUS_BITS + 1;
	localparam int DT = RADIUS_BITS + 3;
	localparam int QW = 2 * RW + 1;

	// Stage 1: differences, radius sum and filter checks.
	logic                     v_s1, ok_s1;
	logic signed [CW-1:0]     dx_s1, dy_s1;
	logic        [RW-1:0]     rs_s1;
	logic signed [COORD_BITS-1:0] ax_s1, ay_s1;
	logic        [RADIUS_BITS-1:0] ar_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= CW'(b_x) - CW'(a_x);
			dy_s1 <= CW'(b_y) - CW'(a_y);
			rs_s1 <= RW'(a_radius) + RW'(b_radius);
			ok_s1 <= !a_doomed && (func || (((a_mask & b_category) != '0) && !b_doomed));
			ax_s1 <= a_x;
			ay_s1 <= a_y;
			ar_s1 <= a_radius;
		end
	end

	// Stage 2: squares, range check and rotation start vectors.
	logic [CW-1:0] adx, ady;
	logic          neg;
	logic signed [DT-1:0] dxt, dyt;
	logic signed [UW-1:0] r0;

	always_comb begin
		adx = dx_s1[CW-1] ? CW'(-dx_s1) : CW'(dx_s1);
		ady = dy_s1[CW-1] ? CW'(-dy_s1) : CW'(dy_s1);
		neg = dx_s1[CW-1];
		dxt = dx_s1[DT-1:0];
		dyt = dy_s1[DT-1:0];
		r0  = UW'({ar_s1, {ccc_pkg::RAD_EXT{1'b0}}});
	end

	logic                 v_s2, ok_s2, inr_s2, zero_s2;
	logic [QW-1:0]        sqx_s2, sqy_s2, rs2_s2;
	logic signed [DW-1:0] x_s2, y_s2;
	logic signed [UW-1:0] u_s2;
	logic signed [COORD_BITS-1:0] ax_s2, ay_s2;
	logic        [RADIUS_BITS-1:0] ar_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2   <= ok_s1;
			inr_s2  <= (adx <= CW'(rs_s1)) && (ady <= CW'(rs_s1));
			zero_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
			sqx_s2  <= QW'(adx[RW-1:0]) * QW'(adx[RW-1:0]);
			sqy_s2  <= QW'(ady[RW-1:0]) * QW'(ady[RW-1:0]);
			rs2_s2  <= QW'(rs_s1) * QW'(rs_s1);
			x_s2    <= neg ? DW'(-(DW'(dxt) <<< ccc_pkg::DIR_EXT))
			               : DW'(dxt) <<< ccc_pkg::DIR_EXT;
			y_s2    <= neg ? DW'(-(DW'(dyt) <<< ccc_pkg::DIR_EXT))
			               : DW'(dyt) <<< ccc_pkg::DIR_EXT;
			u_s2    <= neg ? UW'(-r0) : r0;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			ar_s2   <= ar_s1;
		end
	end

	// Stage 3: exact distance compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out.valid <= v_s2;
			ctl_out.hit   <= ok_s2 && inr_s2 && ((sqx_s2 + sqy_s2) <= rs2_s2);
			ctl_out.zero  <= zero_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out  <= x_s2;
			y_out  <= y_s2;
			u_out  <= u_s2;
			ax_out <= ax_s2;
			ay_out <= ay_s2;
			ar_out <= ar_s2;
		end
	end

endmodule

FILE: hdl/ccc_cell.sv
module ccc_cell #(
	parameter int DW = 44,
	parameter int UW = 26,
	parameter int SW = 64,
	parameter int SHIFT = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  ccc_pkg::ctl_t        ctl_in,
	input  logic signed [DW-1:0] x_in,
	input  logic signed [DW-1:0] y_in,
	input  logic signed [UW-1:0] u_in,
	input  logic signed [UW-1:0] v_in,
	input  logic        [SW-1:0] side_in,
	output ccc_pkg::ctl_t        ctl_out,
	output logic signed [DW-1:0] x_out,
	output logic signed [DW-1:0] y_out,
	output logic signed [UW-1:0] u_out,
	output logic signed [UW-1:0] v_out,
	output logic        [SW-1:0] side_out
);

	// One vectoring step; the companion vector turns the opposite way.
	logic signed [DW-1:0] nx, ny;
	logic signed [UW-1:0] nu, nv;

	always_comb begin
		if (!y_in[DW-1]) begin
			nx = x_in + (y_in >>> SHIFT);
			ny = y_in - (x_in >>> SHIFT);
			nu = u_in - (v_in >>> SHIFT);
			nv = v_in + (u_in >>> SHIFT);
		end else begin
			nx = x_in - (y_in >>> SHIFT);
			ny = y_in + (x_in >>> SHIFT);
			nu = u_in + (v_in >>> SHIFT);
			nv = v_in - (u_in >>> SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out    <= nx;
			y_out    <= ny;
			u_out    <= nu;
			v_out    <= nv;
			side_out <= side_in;
		end
	end

endmodule

FILE: hdl/ccc_back.sv
module ccc_back #(
	parameter int COORD_BITS = 24,
	parameter int RADIUS_BITS = 16,
	parameter int UW = 26
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  ccc_pkg::ctl_t                 ctl_in,
	input  logic signed [UW-1:0]          u_in,
	input  logic signed [UW-1:0]          v_in,
	input  logic signed [COORD_BITS-1:0]  ax_in,
	input  logic signed [COORD_BITS-1:0]  ay_in,
	input  logic        [RADIUS_BITS-1:0] ar_in,
	output logic                          valid_out,
	output logic                          hit_out,
	output logic signed [COORD_BITS-1:0]  px_out,
	output logic signed [COORD_BITS-1:0]  py_out
);

	localparam int PW = UW + ccc_pkg::GAIN_BITS;
	localparam int OW = PW - ccc_pkg::ROUND_SHIFT;
	localparam int SUMW = (COORD_BITS > RADIUS_BITS ? COORD_BITS : RADIUS_BITS) + 4;
	localparam logic signed [SUMW-1:0] HI = SUMW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [SUMW-1:0] LO = SUMW'(-(64'sd1 <<< (COORD_BITS - 1)));

	// Gain multiply.
	ccc_pkg::ctl_t        ctl_s4;
	logic signed [PW-1:0] pu_s4, pv_s4;
	logic signed [COORD_BITS-1:0] ax_s4, ay_s4;
	logic        [RADIUS_BITS-1:0] ar_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pu_s4 <= PW'(u_in) * $signed(PW'(ccc_pkg::GAIN_INV));
			pv_s4 <= PW'(v_in) * $signed(PW'(ccc_pkg::GAIN_INV));
			ax_s4 <= ax_in;
			ay_s4 <= ay_in;
			ar_s4 <= ar_in;
		end
	end

	// Round, offset from A's centre (by A's radius along x when the centres coincide) and saturate.
	logic signed [PW-1:0]   ru, rv;
	logic signed [OW-1:0]   ou, ov;
	logic signed [SUMW-1:0] sx, sy;
	logic signed [COORD_BITS-1:0] cx, cy;

	always_comb begin
		ru = pu_s4 + PW'(64'sd1 <<< (ccc_pkg::ROUND_SHIFT - 1));
		rv = pv_s4 + PW'(64'sd1 <<< (ccc_pkg::ROUND_SHIFT - 1));
		ou = ru[PW-1:ccc_pkg::ROUND_SHIFT];
		ov = rv[PW-1:ccc_pkg::ROUND_SHIFT];
		if (ctl_s4.zero) begin
			sx = SUMW'(ax_s4) + $signed(SUMW'(ar_s4));
			sy = SUMW'(ay_s4);
		end else begin
			sx = SUMW'(ax_s4) + SUMW'(ou);
			sy = SUMW'(ay_s4) + SUMW'(ov);
		end
		if (sx > HI) cx = HI[COORD_BITS-1:0];
		else if (sx < LO) cx = LO[COORD_BITS-1:0];
		else cx = sx[COORD_BITS-1:0];
		if (sy > HI) cy = HI[COORD_BITS-1:0];
		else if (sy < LO) cy = LO[COORD_BITS-1:0];
		else cy = sy[COORD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= ctl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_out <= ctl_s4.hit;
			px_out  <= ctl_s4.hit ? cx : '0;
			py_out  <= ctl_s4.hit ? cy : '0;
		end
	end

endmodule

FILE: hdl/circle_collision_contact.sv
// Circle pair collision test with contact point. Every input beat carries one pair of
// circles and yields exactly one output beat, in order. A pair hits when its filter
// checks pass (func 0: A's mask meets B's category and neither circle is marked for
// removal; func 1: only A's removal mark) and the squared centre distance is at most
// the squared radius sum, compared exactly. On a hit the contact point is A's centre
// plus A's radius along the direction toward B, found by a row of CORDIC vectoring
// cells, then scaled by the inverse gain, rounded and saturated; on a miss both
// coordinates are zero. The block takes one beat per clock while its holding register
// is empty, and it is built from three front stages, one cell per rotation step and two
// back stages. A refused output beat moves into a one-beat holding register and the
// whole pipeline stops only while that register is occupied, so a back-pressured output
// stalls the input only once that register has filled, and s_tready comes straight from a flop.
module circle_collision_contact #(
	parameter int COORD_BITS = 24,
	parameter int RADIUS_BITS = 16,
	parameter int MASK_BITS = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// a_x, a_y, a_radius, a_mask, a_doomed, b_x, b_y, b_radius, b_category, b_doomed
	input  logic [((4*COORD_BITS + 2*RADIUS_BITS + 2*MASK_BITS + 2 + 7) / 8) * 8 - 1:0] s_tdata,
	// func
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// point_x, point_y
	output logic [((2*COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// hit
	output logic m_tuser
);

	localparam int OTW = ((2*COORD_BITS + 7) / 8) * 8;
	// Rotation width: a hit limits the difference to RADIUS_BITS + 3 bits,
	// plus the direction scaling and one bit of CORDIC growth.
	localparam int DW = RADIUS_BITS + 3 + ccc_pkg::DIR_EXT + 1;
	localparam int UW = RADIUS_BITS + ccc_pkg::RAD_EXT + 2;
	localparam int SW = 2 * COORD_BITS + RADIUS_BITS;

	// Field offsets inside s_tdata.
	localparam int O_AY = COORD_BITS;
	localparam int O_AR = 2 * COORD_BITS;
	localparam int O_AM = O_AR + RADIUS_BITS;
	localparam int O_AD = O_AM + MASK_BITS;
	localparam int O_BX = O_AD + 1;
	localparam int O_BY = O_BX + COORD_BITS;
	localparam int O_BR = O_BY + COORD_BITS;
	localparam int O_BC = O_BR + RADIUS_BITS;
	localparam int O_BD = O_BC + MASK_BITS;

	// Holding register for a refused beat.
	logic            sk_valid_q;
	logic            sk_hit_q;
	logic [OTW-1:0]  sk_data_q;

	// One enable moves every stage; it drops only while the holding register is full.
	logic en;
	assign en       = !sk_valid_q;
	assign s_tready = en;

	ccc_pkg::ctl_t        c_ctl  [0:CORDIC_STAGES];
	logic signed [DW-1:0] c_x    [0:CORDIC_STAGES];
	logic signed [DW-1:0] c_y    [0:CORDIC_STAGES];
	logic signed [UW-1:0] c_u    [0:CORDIC_STAGES];
	logic signed [UW-1:0] c_v    [0:CORDIC_STAGES];
	logic        [SW-1:0] c_side [0:CORDIC_STAGES];

	logic signed [COORD_BITS-1:0]  f_ax, f_ay;
	logic        [RADIUS_BITS-1:0] f_ar;

	ccc_front #(
		.COORD_BITS (COORD_BITS),
		.RADIUS_BITS(RADIUS_BITS),
		.MASK_BITS  (MASK_BITS),
		.DW         (DW),
		.UW         (UW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (s_tvalid),
		.func      (s_tuser),
		.a_x       (s_tdata[COORD_BITS-1:0]),
		.a_y       (s_tdata[O_AY +: COORD_BITS]),
		.a_radius  (s_tdata[O_AR +: RADIUS_BITS]),
		.a_mask    (s_tdata[O_AM +: MASK_BITS]),
		.a_doomed  (s_tdata[O_AD]),
		.b_x       (s_tdata[O_BX +: COORD_BITS]),
		.b_y       (s_tdata[O_BY +: COORD_BITS]),
		.b_radius  (s_tdata[O_BR +: RADIUS_BITS]),
		.b_category(s_tdata[O_BC +: MASK_BITS]),
		.b_doomed  (s_tdata[O_BD]),
		.ctl_out   (c_ctl[0]),
		.x_out     (c_x[0]),
		.y_out     (c_y[0]),
		.u_out     (c_u[0]),
		.ax_out    (f_ax),
		.ay_out    (f_ay),
		.ar_out    (f_ar)
	);

	// The companion vector starts on the x axis; the centre of A and its radius
	// ride along so the back end can form the point.
	assign c_v[0]    = '0;
	assign c_side[0] = {f_ar, f_ay, f_ax};

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		ccc_cell #(
			.DW   (DW),
			.UW   (UW),
			.SW   (SW),
			.SHIFT(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (c_ctl[i]),
			.x_in    (c_x[i]),
			.y_in    (c_y[i]),
			.u_in    (c_u[i]),
			.v_in    (c_v[i]),
			.side_in (c_side[i]),
			.ctl_out (c_ctl[i+1]),
			.x_out   (c_x[i+1]),
			.y_out   (c_y[i+1]),
			.u_out   (c_u[i+1]),
			.v_out   (c_v[i+1]),
			.side_out(c_side[i+1])
		);
	end

	logic                         b_valid, b_hit;
	logic signed [COORD_BITS-1:0] px, py;

	ccc_back #(
		.COORD_BITS (COORD_BITS),
		.RADIUS_BITS(RADIUS_BITS),
		.UW         (UW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_in   (c_ctl[CORDIC_STAGES]),
		.u_in     (c_u[CORDIC_STAGES]),
		.v_in     (c_v[CORDIC_STAGES]),
		.ax_in    (c_side[CORDIC_STAGES][COORD_BITS-1:0]),
		.ay_in    (c_side[CORDIC_STAGES][2*COORD_BITS-1:COORD_BITS]),
		.ar_in    (c_side[CORDIC_STAGES][SW-1:2*COORD_BITS]),
		.valid_out(b_valid),
		.hit_out  (b_hit),
		.px_out   (px),
		.py_out   (py)
	);

	// A finished beat that the receiver refuses is parked here while the pipeline
	// moves once more; the parked beat always goes out before the newer one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sk_valid_q <= 1'b0;
		end else if (sk_valid_q) begin
			if (m_tready) sk_valid_q <= 1'b0;
		end else if (b_valid && !m_tready) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!sk_valid_q && b_valid && !m_tready) begin
			sk_hit_q  <= b_hit;
			sk_data_q <= OTW'({py, px});
		end
	end

	assign m_tvalid = sk_valid_q || b_valid;
	assign m_tuser  = sk_valid_q ? sk_hit_q : b_hit;
	assign m_tdata  = sk_valid_q ? sk_data_q : OTW'({py, px});

	// A missed pair always reports the origin.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss beat carries a nonzero point");

	// A full holding register freezes the whole pipeline, input included.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		sk_valid_q |-> !s_tready)
		else $error("input taken while holding register full");

	// An output beat that waits keeps its hit flag.
	a_hold_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser))
		else $error("hit flag changed during stall");

endmodule

FILE: bench/tb_circle_collision_contact.sv
module tb_circle_collision_contact;

	localparam int CW = 24;
	localparam int RW = 16;
	localparam int MW = 16;
	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 5;
	localparam int SW = ((4*CW + 2*RW + 2*MW + 2 + 7) / 8) * 8;
	localparam int MDW = ((2*CW + 7) / 8) * 8;
	localparam longint CYCLE_LIMIT = 400000;

	localparam logic FUNC_PAIR = 1'b0;
	localparam logic FUNC_FREE = 1'b1;

	typedef struct {
		logic func;
		logic signed [CW-1:0] ax, ay;
		logic [RW-1:0] ar;
		logic [MW-1:0] amask;
		logic adoomed;
		logic signed [CW-1:0] bx, by;
		logic [RW-1:0] br;
		logic [MW-1:0] bcat;
		logic bdoomed;
	} pair_t;

	typedef struct {
		logic hit;
		logic [CW-1:0] px, py;
	} contact_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [SW-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [MDW-1:0] m_tdata;
	logic m_tuser;

	contact_t pending_contacts[$];
	int mismatches = 0;
	longint cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;

	circle_collision_contact uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Arithmetic shift right with rounding toward minus infinity.
	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp_coord(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (CW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// Predicts the hit flag and the contact point for one pair.
	function automatic contact_t predict_contact(pair_t p);
		contact_t c;
		logic hit;
		longint ax, ay, bx, by, ar, br, dx, dy, adx, ady, rs, px, py;
		longint x, y, u, v, nx, ny, nu, nv;
		hit = 1'b1;
		ax = longint'(p.ax); ay = longint'(p.ay);
		bx = longint'(p.bx); by = longint'(p.by);
		ar = longint'(p.ar); br = longint'(p.br);
		px = 0; py = 0;
		if (p.adoomed) hit = 1'b0;
		if (p.func == FUNC_PAIR && ((p.amask & p.bcat) == '0 || p.bdoomed)) hit = 1'b0;
		dx = bx - ax;
		dy = by - ay;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		rs = ar + br;
		if (hit && (adx > rs || ady > rs || adx*adx + ady*ady > rs*rs)) hit = 1'b0;
		if (hit) begin
			if (dx == 0 && dy == 0) begin
				px = ax + ar;
				py = ay;
			end else begin
				x = dx <<< 24;
				y = dy <<< 24;
				u = ar <<< 8;
				v = 0;
				if (x < 0) begin
					x = -x; y = -y; u = -u;
				end
				for (int i = 0; i < STAGES; i++) begin
					if (y >= 0) begin
						nx = x + shr_floor(y, i);
						ny = y - shr_floor(x, i);
						nu = u - shr_floor(v, i);
						nv = v + shr_floor(u, i);
					end else begin
						nx = x - shr_floor(y, i);
						ny = y + shr_floor(x, i);
						nu = u + shr_floor(v, i);
						nv = v - shr_floor(u, i);
					end
					x = nx; y = ny; u = nu; v = nv;
				end
				px = ax + shr_floor(u * 10188014 + (longint'(1) <<< 31), 32);
				py = ay + shr_floor(v * 10188014 + (longint'(1) <<< 31), 32);
			end
			px = clamp_coord(px);
			py = clamp_coord(py);
		end
		c.hit = hit;
		c.px = px[CW-1:0];
		c.py = py[CW-1:0];
		return c;
	endfunction

	// Offers one pair, with a random idle gap first, and waits until it is taken.
	task automatic send_pair(pair_t p);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= p.func;
		s_tdata <= SW'({p.bdoomed, p.bcat, p.br, p.by, p.bx,
			p.adoomed, p.amask, p.ar, p.ay, p.ax});
		do @(posedge clk); while (!s_tready);
		pending_contacts.push_back(predict_contact(p));
	endtask

	task automatic go_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		go_quiet();
		while (pending_contacts.size() > 0) @(posedge clk);
	endtask

	function automatic pair_t random_pair();
		pair_t p;
		int mode;
		logic signed [CW-1:0] off;
		p.func = 1'($urandom_range(1));
		p.amask = MW'($urandom);
		p.bcat = MW'($urandom);
		p.adoomed = $urandom_range(9) == 0;
		p.bdoomed = $urandom_range(9) == 0;
		mode = $urandom_range(9);
		p.ar = (mode < 7) ? RW'($urandom_range(4095)) : RW'($urandom);
		p.br = (mode < 7) ? RW'($urandom_range(4095)) : RW'($urandom);
		p.ax = CW'($urandom);
		p.ay = CW'($urandom);
		if (mode < 8) begin
			// Place B near A so that most pairs land close to the touching distance.
			off = CW'($signed(CW'($urandom_range(2*(p.ar + p.br) + 2)))
				- (p.ar + p.br) - 1);
			p.bx = p.ax + off;
			off = CW'($signed(CW'($urandom_range(2*(p.ar + p.br) + 2)))
				- (p.ar + p.br) - 1);
			p.by = p.ay + off;
			if (mode == 0) p.by = p.ay;
			if (mode == 1) p.bx = p.ax;
		end else begin
			p.bx = CW'($urandom);
			p.by = CW'($urandom);
		end
		return p;
	endfunction

	function automatic pair_t make_pair(logic func, longint ax, longint ay, longint ar,
			longint bx, longint by, longint br);
		pair_t p;
		p.func = func;
		p.ax = CW'(ax); p.ay = CW'(ay); p.ar = RW'(ar);
		p.bx = CW'(bx); p.by = CW'(by); p.br = RW'(br);
		p.amask = '1; p.bcat = '1;
		p.adoomed = 1'b0; p.bdoomed = 1'b0;
		return p;
	endfunction

	// Checker: compares each output beat with the oldest prediction.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_contacts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: hit=%0b x=%h y=%h", m_tuser,
						m_tdata[CW-1:0], m_tdata[2*CW-1:CW]);
			end else begin
				contact_t e;
				e = pending_contacts.pop_front();
				if (e.hit !== m_tuser || e.px !== m_tdata[CW-1:0]
						|| e.py !== m_tdata[2*CW-1:CW]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected hit=%0b x=%h y=%h, got hit=%0b x=%h y=%h",
							e.hit, e.px, e.py, m_tuser, m_tdata[CW-1:0], m_tdata[2*CW-1:CW]);
				end
			end
		end
	end

	// Receiver: random stalls, or a long hold-off counted down in cycles.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Extremes of every field, both functions, the filter rejections, coincident
	// centres, touching circles and saturation at the coordinate limits.
	task automatic test_directed();
		pair_t p;
		longint cmax;
		cmax = (longint'(1) <<< (CW-1)) - 1;
		send_pair(make_pair(FUNC_PAIR, 0, 0, 256, 0, 0, 256));
		send_pair(make_pair(FUNC_FREE, 100, -100, 0, 100, -100, 0));
		send_pair(make_pair(FUNC_PAIR, 0, 0, 256, 512, 0, 256));
		send_pair(make_pair(FUNC_PAIR, 0, 0, 256, 513, 0, 256));
		send_pair(make_pair(FUNC_PAIR, 0, 0, 1000, -700, 300, 100));
		send_pair(make_pair(FUNC_FREE, 0, 0, 1000, 0, -900, 100));
		send_pair(make_pair(FUNC_PAIR, 0, 0, 1000, -600, -600, 500));
		send_pair(make_pair(FUNC_PAIR, cmax, cmax, 65535, cmax, cmax, 65535));
		send_pair(make_pair(FUNC_PAIR, -cmax-1, -cmax-1, 65535, -cmax-1+100,
			-cmax-1+100, 65535));
		send_pair(make_pair(FUNC_FREE, cmax-10, 0, 65535, cmax, 0, 0));
		send_pair(make_pair(FUNC_PAIR, -cmax-1, 0, 65535, -cmax-1 - 0, -50, 65535));
		send_pair(make_pair(FUNC_PAIR, -cmax-1, -cmax-1, 65535, cmax, cmax, 65535));
		p = make_pair(FUNC_PAIR, 0, 0, 300, 10, 10, 300);
		p.amask = 16'h00f0; p.bcat = 16'h0f0f;
		send_pair(p);
		p.func = FUNC_FREE;
		send_pair(p);
		p = make_pair(FUNC_PAIR, 0, 0, 300, 10, 10, 300);
		p.bdoomed = 1'b1;
		send_pair(p);
		p.func = FUNC_FREE;
		send_pair(p);
		p.adoomed = 1'b1;
		send_pair(p);
		p = make_pair(FUNC_PAIR, 0, 0, 300, 10, 10, 300);
		p.amask = 16'h8000; p.bcat = 16'h8000;
		send_pair(p);
		p.amask = 16'h0001; p.bcat = 16'h0001;
		send_pair(p);
		wait_drained();
	endtask

	task automatic test_random(int count, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_pair(random_pair());
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// The receiver holds off long enough for the pipeline to fill and block
	// its input, and the sender keeps offering beats the whole time.
	task automatic test_backpressure();
		hold_off = 3 * LATENCY;
		repeat (2 * LATENCY) send_pair(random_pair());
		wait_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(450, 0, 0);
		wait_drained();
		test_random(400, 66, 0);
		test_random(400, 0, 66);
		test_random(450, 25, 25);
		test_backpressure();
		go_quiet();
		while (pending_contacts.size() > 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (mismatches == 0 && pending_contacts.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/ccc_pkg.sv
hdl/ccc_front.sv
hdl/ccc_cell.sv
hdl/ccc_back.sv
hdl/circle_collision_contact.sv
bench/tb_circle_collision_contact.sv
